>>> rtl/truth_value_inference_unit_macros.svh
// ----------------------------------------------------------------------------
// Truth-value inference unit: assertion macros
// Shared shorthand for the concurrent checks on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TRUTH_VALUE_INFERENCE_UNIT_MACROS_SVH
`define TRUTH_VALUE_INFERENCE_UNIT_MACROS_SVH

// same-cycle implication
`define TVIU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tviu check failed");

// next-cycle implication
`define TVIU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tviu check failed");

`endif

>>> rtl/tviu_pkg.sv
// ----------------------------------------------------------------------------
// tviu_pkg
// Types, codes and fixed-point constants of the truth-value inference unit.
// ----------------------------------------------------------------------------
package tviu_pkg;

  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [15:0] K_0P8      = 16'd26214;
  localparam logic [15:0] K_0P9      = 16'd29491;
  localparam logic [15:0] K_0P6      = 16'd19661;
  localparam logic [15:0] K_0P7      = 16'd22938;
  localparam logic [16:0] MIN_WEIGHT = 17'd328;
  localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;
  localparam logic [15:0] THR_RESET  = 16'd19661;
  localparam logic [15:0] RW_RESET   = 16'd26214;
  localparam int unsigned DIV_STEPS  = 48;

  typedef enum logic [2:0] {
    RT_MP  = 3'd0,
    RT_DED = 3'd1,
    RT_IND = 3'd2,
    RT_ABD = 3'd3,
    RT_REV = 3'd4
  } rule_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD    = 2'd1,
    ST_LOW    = 2'd2,
    ST_WEIGHT = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_THR = 1'b0,
    REG_RW  = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] first_strength;
    logic [15:0] first_confidence;
    logic [23:0] first_count;
    logic [15:0] second_strength;
    logic [15:0] second_confidence;
    logic [23:0] second_count;
    logic        first_found;
    logic        first_is_implication;
    logic        second_found;
    logic        second_is_implication;
    logic        chain_matches;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic [15:0] result_strength;
    logic [15:0] result_confidence;
    logic [23:0] result_count;
    logic [31:0] success_total;
    logic [31:0] failure_total;
  } out_t;

  function automatic logic [15:0] clamp_q15(logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

>>> rtl/truth_value_inference_unit.sv
// ----------------------------------------------------------------------------
// truth_value_inference_unit
// Combines two premise truth values under one inference rule, with a
// shared multiplier and a shared radix-2 divider under a small sequencer.
// ----------------------------------------------------------------------------
// Use:
//  - Input channel in_valid_i / in_stall_o carries one request word. It is
//    taken when valid is high and stall is low; stall stays high from then
//    until the result has gone into the output register.
//  - Output channel out_valid_o / out_stall_i carries one result word per
//    request. The output register holds while out_stall_i is high; a new
//    request is taken meanwhile, and its result waits in the sequencer.
//  - Config port cfg_valid_i / cfg_ready_o is always ready; index 0 is the
//    confidence threshold, index 1 the revision weight. Write only when idle.
//  - Path per request: bad premises or an unknown rule go from the multiply
//    state straight to done; modus ponens runs multiply then finish; revision
//    with too little weight skips divide and finish; the other rules add one
//    48-step division (one quotient bit a cycle). The next word is taken in
//    the cycle after the load at the earliest; a stalled output delays it.
//  - Reset clears the counters, the output valid and the sequencer, and
//    loads the register defaults (threshold 0.6, revision weight 0.8).
// ----------------------------------------------------------------------------
`include "truth_value_inference_unit_macros.svh"

module truth_value_inference_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tviu_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tviu_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [15:0]     cfg_data_i
);
  import tviu_pkg::*;

  // sequencer
  state_e      state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        load_out;

  // config
  logic [15:0] thr_q, rw_q;

  // latched request
  logic [2:0]  rule_q;
  logic [15:0] a_q, b_q, c1_q, c2_q;
  logic [23:0] n1_q, n2_q, nmin_q;
  logic        valid_q, counted_q;
  logic        req_ok, req_known;

  // working registers
  logic [30:0] ab_q, cc_q;
  logic [15:0] wn_q;
  logic [47:0] tmp_q;
  logic [47:0] dq_q;
  logic [31:0] dv_q, rem_q;
  logic        dz_q;
  logic [1:0]  status_q;
  logic [15:0] s_q, c_q, thr_eff_q;
  logic [23:0] n_q;

  // results
  logic [31:0] succ_q, fail_q, succ_d, fail_d;
  logic        out_valid_q;
  out_t        out_q;
  logic [1:0]  st_fin;

  // shared multiplier
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  assign prod = op_a * op_b;

  logic [16:0] t_w;
  logic [15:0] t_clamp, q_clamp;
  logic [32:0] trial, diff;
  logic [24:0] nsum;

  assign t_w     = {1'b0, c1_q} + {1'b0, wn_q};
  assign t_clamp = (t_w > {1'b0, ONE_Q15}) ? ONE_Q15 : t_w[15:0];
  assign q_clamp = dz_q ? 16'd0 :
                   ((dq_q > {32'd0, ONE_Q15}) ? ONE_Q15 : dq_q[15:0]);
  assign trial   = {rem_q, dq_q[47]};
  assign diff    = trial - {1'b0, dv_q};
  assign nsum    = {1'b0, n1_q} + {1'b0, n2_q};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // premise check at the input
  always_comb begin
    req_known = 1'b1;
    case (in_data_i.req_type)
      RT_MP, RT_IND, RT_ABD: req_ok = in_data_i.first_found &
                                      in_data_i.first_is_implication &
                                      in_data_i.second_found;
      RT_DED: req_ok = in_data_i.first_found & in_data_i.second_found &
                       in_data_i.first_is_implication &
                       in_data_i.second_is_implication &
                       in_data_i.chain_matches;
      RT_REV: req_ok = in_data_i.first_found & in_data_i.second_found;
      default: begin
        req_ok    = 1'b0;
        req_known = 1'b0;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a = 32'd0;
    op_b = 32'd0;
    case (state_q)
      S_MUL: begin
        case (step_q)
          2'd0: begin
            if (rule_q == RT_REV) begin
              op_a = {16'd0, c2_q};
              op_b = {16'd0, clamp_q15(rw_q)};
            end else begin
              op_a = {16'd0, a_q};
              op_b = {16'd0, b_q};
            end
          end
          2'd1: begin
            op_a = (rule_q == RT_REV) ? {16'd0, a_q} : {16'd0, c1_q};
            op_b = {16'd0, c1_q};
            if (rule_q != RT_REV) op_b = {16'd0, c2_q};
          end
          2'd2: begin
            case (rule_q)
              RT_DED: begin
                op_a = {8'd0, n1_q};
                op_b = {8'd0, n2_q};
              end
              RT_IND: begin
                op_a = {16'd0, ONE_Q15 - a_q};
                op_b = {16'd0, b_q};
              end
              RT_ABD: begin
                op_a = {16'd0, ONE_Q15 - a_q};
                op_b = {16'd0, ONE_Q15 - b_q};
              end
              RT_REV: begin
                op_a = {16'd0, b_q};
                op_b = {16'd0, wn_q};
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_FIN: begin
        case (step_q)
          2'd0: begin
            op_a = {1'b0, cc_q};
            case (rule_q)
              RT_DED:  op_b = dq_q[31:0];
              RT_IND:  op_b = {16'd0, K_0P8};
              default: op_b = {16'd0, K_0P6};
            endcase
          end
          2'd1: begin
            op_a = {8'd0, nmin_q};
            op_b = (rule_q == RT_IND) ? {16'd0, K_0P9} : {16'd0, K_0P7};
          end
          default: begin
            op_a = {16'd0, clamp_q15(thr_q)};
            op_b = {16'd0, K_0P8};
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    cnt_d    = cnt_q;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
          step_d  = 2'd0;
        end
      end
      S_MUL: begin
        if (!valid_q) begin
          state_d = S_DONE;
        end else if (step_q == 2'd3) begin
          step_d = 2'd0;
          cnt_d  = 6'd0;
          if (rule_q == RT_MP) state_d = S_FIN;
          else if (rule_q == RT_REV && t_w < MIN_WEIGHT) state_d = S_DONE;
          else state_d = S_DIV;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      S_DIV: begin
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
          step_d  = 2'd0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_FIN: begin
        if (step_q == 2'd2) state_d = S_DONE;
        else step_d = step_q + 2'd1;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 2'd0;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      rw_q  <= RW_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THR: thr_q <= cfg_data_i;
        REG_RW:  rw_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rule_q    <= in_data_i.req_type;
          a_q       <= clamp_q15(in_data_i.first_strength);
          c1_q      <= clamp_q15(in_data_i.first_confidence);
          b_q       <= clamp_q15(in_data_i.second_strength);
          c2_q      <= clamp_q15(in_data_i.second_confidence);
          n1_q      <= in_data_i.first_count;
          n2_q      <= in_data_i.second_count;
          nmin_q    <= (in_data_i.first_count < in_data_i.second_count) ?
                       in_data_i.first_count : in_data_i.second_count;
          valid_q   <= req_ok;
          counted_q <= req_known;
          status_q  <= req_ok ? ST_OK : ST_BAD;
          s_q       <= 16'd0;
          c_q       <= 16'd0;
          n_q       <= 24'd0;
        end
      end
      S_MUL: begin
        case (step_q)
          2'd0: begin
            if (rule_q == RT_REV) wn_q <= prod[30:15];
            else ab_q <= prod[30:0];
          end
          2'd1: begin
            if (rule_q == RT_REV) tmp_q <= prod[47:0];
            else cc_q <= prod[30:0];
          end
          2'd2: begin
            if (rule_q == RT_REV) tmp_q <= tmp_q + prod[47:0];
            else tmp_q <= prod[47:0];
          end
          default: begin
            rem_q <= 32'd0;
            case (rule_q)
              RT_DED: begin
                dq_q <= tmp_q;
                dv_q <= {8'd0, n1_q} + {8'd0, n2_q} + 32'd256;
                dz_q <= 1'b0;
              end
              RT_IND, RT_ABD: begin
                dq_q <= {2'd0, ab_q, 15'd0};
                dv_q <= {1'b0, a_q, 15'd0} + tmp_q[31:0];
                dz_q <= ({1'b0, a_q, 15'd0} + tmp_q[31:0]) == 32'd0;
              end
              default: begin
                dq_q <= tmp_q;
                dv_q <= {15'd0, t_w};
                dz_q <= 1'b0;
                if (rule_q == RT_REV && t_w < MIN_WEIGHT) status_q <= ST_WEIGHT;
              end
            endcase
          end
        endcase
      end
      S_DIV: begin
        // one restoring step: shift in a dividend bit, subtract if it fits
        if (!diff[32]) begin
          rem_q <= diff[31:0];
          dq_q  <= {dq_q[46:0], 1'b1};
        end else begin
          rem_q <= trial[31:0];
          dq_q  <= {dq_q[46:0], 1'b0};
        end
      end
      S_FIN: begin
        case (step_q)
          2'd0: begin
            thr_eff_q <= clamp_q15(thr_q);
            case (rule_q)
              RT_MP: begin
                s_q <= ab_q[30:15];
                c_q <= cc_q[30:15];
                n_q <= nmin_q;
              end
              RT_DED: begin
                s_q <= ab_q[30:15];
                c_q <= (prod[63:38] > {10'd0, ONE_Q15}) ? ONE_Q15 : prod[53:38];
                n_q <= nmin_q;
              end
              RT_IND, RT_ABD: begin
                s_q <= q_clamp;
                c_q <= prod[45:30];
              end
              default: begin
                s_q <= q_clamp;
                c_q <= t_clamp;
                n_q <= nsum[24] ? COUNT_MAX : nsum[23:0];
              end
            endcase
          end
          2'd1: begin
            if (rule_q == RT_IND || rule_q == RT_ABD) n_q <= prod[38:15];
          end
          default: begin
            if (rule_q == RT_ABD) thr_eff_q <= prod[30:15];
          end
        endcase
      end
      default: ;
    endcase
  end

  // final status and counters
  always_comb begin
    st_fin = status_q;
    if (status_q == ST_OK && rule_q != RT_REV && c_q < thr_eff_q) st_fin = ST_LOW;
    succ_d = succ_q;
    fail_d = fail_q;
    if (counted_q) begin
      if (st_fin == ST_OK) succ_d = succ_q + 32'd1;
      else fail_d = fail_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      succ_q      <= 32'd0;
      fail_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        succ_q      <= succ_d;
        fail_q      <= fail_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.accepted          <= (st_fin == ST_OK);
      out_q.status            <= st_fin;
      out_q.result_strength   <= s_q;
      out_q.result_confidence <= c_q;
      out_q.result_count      <= n_q;
      out_q.success_total     <= succ_d;
      out_q.failure_total     <= fail_d;
    end
  end

  `TVIU_ASSERT_NXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == S_MUL)
  `TVIU_ASSERT_IMP(a_acc_status, out_valid_o, out_data_o.accepted == (out_data_o.status == ST_OK))
  `TVIU_ASSERT_IMP(a_conf_range, out_valid_o, out_data_o.result_confidence <= ONE_Q15)
  `TVIU_ASSERT_NXT(a_load_sets_valid, load_out, out_valid_q)

endmodule
